/* hdl/tlbpt_pkg.sv */
// ----------------------------------------------------------------------------
// tlbpt_pkg - shared types and constants for the TLB page table translator
// Sizes of the TLB and page table, field widths, and the page-to-index table.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

    // Field widths
    localparam int PAGE_W   = 8;
    localparam int OFFSET_W = 8;
    localparam int FRAME_W  = 8;
    localparam int ADDR_W   = PAGE_W + OFFSET_W;

    // TLB geometry
    localparam int TLB_ENTRIES = 16;
    localparam int TLB_PTR_W   = $clog2(TLB_ENTRIES);

    // Page table geometry: only 2^PAGE_W distinct pages can ever reach it
    localparam int PAGES       = 256;
    localparam int PAGE_SPAN   = 1 << PAGE_W;
    localparam int TABLE_DEPTH = (PAGES < PAGE_SPAN) ? PAGES : PAGE_SPAN;
    localparam int TABLE_IDX_W = $clog2(TABLE_DEPTH);

    typedef logic [PAGE_W-1:0]      page_t;
    typedef logic [OFFSET_W-1:0]    offset_t;
    typedef logic [FRAME_W-1:0]     frame_t;
    typedef logic [TLB_PTR_W-1:0]   tlb_ptr_t;
    typedef logic [TABLE_IDX_W-1:0] table_idx_t;

    typedef table_idx_t page_lut_t [PAGE_SPAN];

    // Result of the associative TLB match
    typedef struct packed {
        logic   hit;
        frame_t frame;
    } tlb_lookup_t;

    // TLB fill request
    typedef struct packed {
        logic   en;
        page_t  page;
        frame_t frame;
    } tlb_insert_t;

    // Page table write request
    typedef struct packed {
        logic       en;
        table_idx_t idx;
        frame_t     frame;
    } table_write_t;

    // Page number to table index (page modulo PAGES), built at elaboration
    function automatic page_lut_t build_page_lut();
        page_lut_t lut;
        for (int i = 0; i < PAGE_SPAN; i++)
        begin
            lut[i] = table_idx_t'(i % TABLE_DEPTH);
        end
        return lut;
    endfunction

    localparam page_lut_t PAGE_LUT = build_page_lut();

endpackage

/* hdl/tlb_page_table_translator.sv */
// ----------------------------------------------------------------------------
// tlb_page_table_translator - virtual to physical address translation
// TLB lookup, page table walk on a miss and demand frame allocation on a fault.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one virtual address per request (page in 15..8, offset in
//   7..0). m_axis returns one result per request, in order: the physical
//   address in tdata and the hit and fault flags in tuser.
//   The input stage captures the address and starts the page table read,
//   and the result register is then loaded from it. One request is taken in
//   every cycle while the receiver keeps up; the rate is set by the single
//   page table read port, which is read once per request.
//   A TLB miss fills the slot under the FIFO pointer; a page fault hands out
//   the next free frame (wrapping after 256) and maps the page.
//   Reset clears the TLB, the page table mapped flags, the FIFO pointer and
//   the free frame counter; no clearing pass is needed.
//   When the receiver stalls the result register holds, the internal stage
//   holds behind it and s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module tlb_page_table_translator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] virtual_address
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] physical_address
    output logic [1:0]  m_axis_tuser    // [0] tlb_hit, [1] page_fault
);

    logic in_fire;
    logic s1_advance;

    logic                   s1_valid_reg;
    tlbpt_pkg::page_t       s1_page_reg;
    tlbpt_pkg::offset_t     s1_offset_reg;
    tlbpt_pkg::table_idx_t  s1_idx_reg;
    tlbpt_pkg::table_idx_t  in_idx;
    tlbpt_pkg::page_t       in_page;

    tlbpt_pkg::frame_t      free_frame_reg;
    tlbpt_pkg::frame_t      free_frame_next;

    tlbpt_pkg::tlb_lookup_t lookup;
    tlbpt_pkg::tlb_insert_t insert;
    tlbpt_pkg::table_write_t tbl_wr;
    tlbpt_pkg::frame_t      tbl_frame;
    logic                   tbl_mapped;

    logic                   hit;
    logic                   fault;
    tlbpt_pkg::frame_t      frame;

    logic                   out_valid_reg;
    logic [15:0]            out_data_reg;
    logic [1:0]             out_user_reg;

    // Handshake
    assign s1_advance    = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign in_page = s_axis_tdata[15:8];
    assign in_idx  = tlbpt_pkg::PAGE_LUT[in_page];

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_page_reg   <= in_page;
            s1_offset_reg <= s_axis_tdata[7:0];
            s1_idx_reg    <= in_idx;
        end
    end

    tlbpt_cam u_cam
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .lookup_page (s1_page_reg),
        .lookup      (lookup),
        .insert      (insert)
    );

    tlbpt_table u_table
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_fire),
        .rd_idx    (in_idx),
        .rd_frame  (tbl_frame),
        .chk_idx   (s1_idx_reg),
        .chk_valid (tbl_mapped),
        .wr        (tbl_wr)
    );

    // Translate: TLB, then page table, then allocate
    always_comb
    begin
        hit   = lookup.hit;
        fault = !lookup.hit && !tbl_mapped;
        priority if (lookup.hit)
        begin
            frame = lookup.frame;
        end
        else if (tbl_mapped)
        begin
            frame = tbl_frame;
        end
        else
        begin
            frame = free_frame_reg;
        end
    end

    // State updates on commit
    always_comb
    begin
        insert.en    = s1_valid_reg && s1_advance && !hit;
        insert.page  = s1_page_reg;
        insert.frame = frame;

        tbl_wr.en    = s1_valid_reg && s1_advance && fault;
        tbl_wr.idx   = s1_idx_reg;
        tbl_wr.frame = free_frame_reg;

        free_frame_next = tbl_wr.en ? free_frame_reg + 1'b1 : free_frame_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_frame_reg <= '0;
        end
        else
        begin
            free_frame_reg <= free_frame_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            out_data_reg <= {frame, s1_offset_reg};
            out_user_reg <= {fault, hit};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

`ifndef ASSERT_OFF
    // Hit and fault exclude each other
    a_hit_xor_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_user_reg[0] && out_user_reg[1]))
        else $error("result flags both a TLB hit and a page fault");

    // Free frame counter moves exactly on a fault commit
    a_free_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_advance && fault) |=>
            (free_frame_reg == $past(free_frame_reg) + 1'b1))
        else $error("free frame counter did not advance on a fault");

    // A stalled request holds in the input stage
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> (s1_valid_reg && $stable(s1_page_reg)))
        else $error("input stage lost a stalled request");

    // A fault commit is reported as a page fault
    a_fault_reported: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_advance && fault) |=> (out_valid_reg && out_user_reg[1]))
        else $error("page fault not reported");
`endif

endmodule

/* hdl/tlbpt_cam.sv */
// ----------------------------------------------------------------------------
// tlbpt_cam - fully associative TLB with FIFO replacement
// Parallel match of one page against every valid slot; fills go to the slot
// under the FIFO pointer, which then moves on modulo the slot count.
// ----------------------------------------------------------------------------
module tlbpt_cam
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  tlbpt_pkg::page_t       lookup_page,
    output tlbpt_pkg::tlb_lookup_t lookup,
    input  tlbpt_pkg::tlb_insert_t insert
);

    localparam tlbpt_pkg::tlb_ptr_t LAST_SLOT =
        tlbpt_pkg::TLB_PTR_W'(tlbpt_pkg::TLB_ENTRIES - 1);

    tlbpt_pkg::page_t  page_reg  [tlbpt_pkg::TLB_ENTRIES];
    tlbpt_pkg::frame_t frame_reg [tlbpt_pkg::TLB_ENTRIES];
    logic [tlbpt_pkg::TLB_ENTRIES-1:0] valid_reg;
    logic [tlbpt_pkg::TLB_ENTRIES-1:0] valid_next;
    tlbpt_pkg::tlb_ptr_t ptr_reg;
    tlbpt_pkg::tlb_ptr_t ptr_next;

    // Match: lowest matching slot wins (duplicates do not arise anyway)
    always_comb
    begin
        lookup.hit   = 1'b0;
        lookup.frame = '0;
        for (int i = tlbpt_pkg::TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (page_reg[i] == lookup_page))
            begin
                lookup.hit   = 1'b1;
                lookup.frame = frame_reg[i];
            end
        end
    end

    // FIFO pointer and valid bits
    always_comb
    begin
        valid_next = valid_reg;
        ptr_next   = ptr_reg;
        if (insert.en)
        begin
            valid_next[ptr_reg] = 1'b1;
            ptr_next = (ptr_reg == LAST_SLOT) ? '0 : ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            ptr_reg   <= ptr_next;
        end
    end

    // Slot payload
    always_ff @(posedge clk)
    begin
        if (insert.en)
        begin
            page_reg[ptr_reg]  <= insert.page;
            frame_reg[ptr_reg] <= insert.frame;
        end
    end

`ifndef ASSERT_OFF
    // A fill always lands in a slot that is then valid
    a_fill_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        insert.en |=> valid_reg[$past(ptr_reg)])
        else $error("TLB fill did not set the slot valid");

    // Pointer only moves on a fill
    a_ptr_moves_on_fill: assert property (@(posedge clk) disable iff (!rst_n)
        !insert.en |=> $stable(ptr_reg))
        else $error("TLB FIFO pointer moved without a fill");

    // Valid bits never clear once set
    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((valid_reg & $past(valid_reg)) == $past(valid_reg)))
        else $error("TLB valid bit cleared");
`endif

endmodule

/* hdl/tlbpt_table.sv */
// ----------------------------------------------------------------------------
// tlbpt_table - directly indexed page table
// Frame memory with a registered read port and a write port, forwarding of a
// same-cycle write to the read, and one valid flop per entry.
// ----------------------------------------------------------------------------
module tlbpt_table
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    rd_en,
    input  tlbpt_pkg::table_idx_t   rd_idx,
    output tlbpt_pkg::frame_t       rd_frame,
    input  tlbpt_pkg::table_idx_t   chk_idx,
    output logic                    chk_valid,
    input  tlbpt_pkg::table_write_t wr
);

    tlbpt_pkg::frame_t mem [tlbpt_pkg::TABLE_DEPTH];
    tlbpt_pkg::frame_t rd_data_reg;
    tlbpt_pkg::frame_t fwd_data_reg;
    logic              fwd_reg;
    logic [tlbpt_pkg::TABLE_DEPTH-1:0] valid_reg;

    // Memory write
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.frame;
        end
    end

    // Registered read, with the colliding write captured alongside
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_idx];
            fwd_data_reg <= wr.frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= wr.en && (wr.idx == rd_idx);
        end
    end

    assign rd_frame = fwd_reg ? fwd_data_reg : rd_data_reg;

    // Mapped flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.idx] <= 1'b1;
        end
    end

    assign chk_valid = valid_reg[chk_idx];

`ifndef ASSERT_OFF
    // A write leaves its entry mapped
    a_write_maps: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |=> valid_reg[$past(wr.idx)])
        else $error("page table write did not map the entry");

    // Forwarded read returns the frame just written
    a_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr.en && (wr.idx == rd_idx)) |=> (rd_frame == $past(wr.frame)))
        else $error("page table forwarding lost a write");

    // Read data holds while no read is issued
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !rd_en |=> ((rd_data_reg === $past(rd_data_reg)) && $stable(fwd_reg)))
        else $error("page table read data changed without a read");
`endif

endmodule
